### rtl/amac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amac_pkg
// Shared widths, defaults and types for the averaging ADC front end.
// ----------------------------------------------------------------------------
package amac_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int OFFSET_W     = 4;
  localparam int CV_W         = 10;

  localparam int WINDOW_DEF   = 10;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(3);

  // 5 V reference in hundredths of a volt over a 1024-step converter
  localparam int FULL_SCALE_W = 9;
  localparam logic [FULL_SCALE_W-1:0] FULL_SCALE_CV = FULL_SCALE_W'(500);
  localparam int SCALE_SHIFT  = 10;

  // output buffer
  localparam int OUT_FIFO_DEPTH = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [CV_W-1:0]     cv_t;

endpackage

### rtl/adc_moving_average_centivolts_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_moving_average_centivolts_top
// Moving average of converter samples, scaled to centivolts plus offset.
// ----------------------------------------------------------------------------
// Takes one 10-bit sample per cycle while in_ready is high and returns one result
// per sample, registered through stages 1, 2 and 3. The last WINDOW samples live
// in a ring memory with a registered read; a running sum is updated from the
// entry being replaced, so the rate is set by that one read-modify-write per item
// and is one item per clock while in_ready is high. Ring entries are marked empty
// by reset and read as zero until written, so the first averages include zeros.
// Results pass through an eight-entry output buffer; the input stays ready while
// fewer than eight items are between input and output.
module adc_moving_average_centivolts_top #(
  parameter int WINDOW = amac_pkg::WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  amac_pkg::sample_t in_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output amac_pkg::cv_t     out_centivolts,
  input  logic              cfg_wr_en,
  input  amac_pkg::offset_t cfg_wr_data
);
  import amac_pkg::*;

  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = SAMPLE_W + IDX_W;
  // reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int QS      = SUM_W + IDX_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**QS + WINDOW - 1) / WINDOW);
  localparam int SCL_W   = SAMPLE_W + 1 + FULL_SCALE_W;
  localparam int PTR_W   = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W   = PTR_W + 1;

  logic in_xfer;
  logic out_xfer;

  offset_t offset_r;

  // ring memory and per-entry valid bits
  sample_t                ring_mem [WINDOW];
  logic [WINDOW-1:0]      ring_vld_r;
  logic [IDX_W-1:0]       widx_r;
  logic [IDX_W-1:0]       widx_nxt;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;

  // stage 1: sample and ring read data
  logic                   s1_vld_r;
  sample_t                s1_sample_r;
  logic [IDX_W-1:0]       s1_pos_r;
  sample_t                rd_data_r;
  logic                   rd_vld_r;
  sample_t                old_sample;

  // stage 2: window sum
  logic                   s2_vld_r;
  logic [SUM_W-1:0]       s2_sum_r;
  logic [PROD_W-1:0]      avg_prod;

  // stage 3: average
  logic                   s3_vld_r;
  sample_t                s3_avg_r;
  logic [SCL_W-1:0]       scaled;
  cv_t                    cv_nxt;

  // output buffer
  cv_t                    fifo_mem [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]       fifo_wptr_r;
  logic [PTR_W-1:0]       fifo_rptr_r;
  logic [CNT_W-1:0]       fifo_cnt_r;
  logic [CNT_W-1:0]       inflight_r;

  assign in_ready = inflight_r < CNT_W'(OUT_FIFO_DEPTH);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = fifo_cnt_r != '0;
  assign out_xfer = out_valid && out_ready;
  assign out_centivolts = fifo_mem[fifo_rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (widx_r == IDX_W'(WINDOW - 1)) begin
      widx_nxt = '0;
    end else begin
      widx_nxt = widx_r + IDX_W'(1);
    end
  end

  // ring read on transfer; the write of the same entry is WINDOW items back
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data_r <= ring_mem[widx_r];
    end
    if (s1_vld_r) begin
      ring_mem[s1_pos_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r     <= '0;
      ring_vld_r <= '0;
      s1_vld_r   <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
      if (in_xfer) begin
        widx_r   <= widx_nxt;
        rd_vld_r <= ring_vld_r[widx_r];
      end
      if (s1_vld_r) begin
        ring_vld_r[s1_pos_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_sample;
      s1_pos_r    <= widx_r;
    end
  end

  // running sum: drop the replaced entry, add the new one
  assign old_sample = rd_vld_r ? rd_data_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_sample) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (s1_vld_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_sum_r <= sum_nxt;
    end
  end

  // divide by window through the reciprocal
  assign avg_prod = PROD_W'(s2_sum_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_avg_r <= avg_prod[QS +: SAMPLE_W];
    end
  end

  assign scaled = (SCL_W'(s3_avg_r) + SCL_W'(1)) * SCL_W'(FULL_SCALE_CV);
  assign cv_nxt = scaled[SCALE_SHIFT +: CV_W] + CV_W'(offset_r);

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      fifo_mem[fifo_wptr_r] <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wptr_r <= '0;
      fifo_rptr_r <= '0;
      fifo_cnt_r  <= '0;
      inflight_r  <= '0;
    end else begin
      if (s3_vld_r) begin
        fifo_wptr_r <= fifo_wptr_r + PTR_W'(1);
      end
      if (out_xfer) begin
        fifo_rptr_r <= fifo_rptr_r + PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(s3_vld_r) - CNT_W'(out_xfer);
      inflight_r <= inflight_r + CNT_W'(in_xfer) - CNT_W'(out_xfer);
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(OUT_FIFO_DEPTH))
    else $error("items in flight exceed output buffer depth");

  a_fifo_within_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= inflight_r)
    else $error("output buffer holds more than was accepted");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && !out_xfer |-> fifo_cnt_r < CNT_W'(OUT_FIFO_DEPTH))
    else $error("output buffer overflow");

  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r <= IDX_W'(WINDOW - 1))
    else $error("ring index out of range");

  a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_vld_r ##1 s2_vld_r ##1 s3_vld_r)
    else $error("accepted item lost in pipeline");

endmodule
